[rtl/xyzlab_pkg.sv]
`default_nettype none
package xyzlab_pkg;

  // Q.18 working format for t and f
  localparam int TFrac = 18;
  localparam int TW    = 28;
  localparam int FW    = 22;
  localparam int NumLanes = 3;

  // White components scaled by 10000
  localparam int unsigned WhiteX = 950489;
  localparam int unsigned WhiteY = 1000000;
  localparam int unsigned WhiteZ = 1088840;

  // Cube-root threshold on t in Q.18: t*24389 > 216*2^18
  localparam logic [47:0] SegLimit = 48'd216 << TFrac;

  // Linear segment constants
  localparam logic [47:0] LinOffset = 48'd432 << TFrac;
  localparam int unsigned LinDiv    = 3132;

  // Rounded-up reciprocal of LinDiv, exact floor for numerators below 2^28
  localparam int          LinShift  = 40;
  localparam logic [63:0] LinRecip  =
    ((64'd1 << LinShift) + 64'(LinDiv) - 64'd1) / 64'(LinDiv);

  typedef logic [TW-1:0] t_val_t;
  typedef logic [FW-1:0] f_val_t;

endpackage
`default_nettype wire

[rtl/xyz_to_cielab_core.sv]
`default_nettype none
// XYZ (D65) to CIELAB converter. Takes one word per clock unless the output
// stalls. The pipeline has two normalize stages, a segment stage, the
// 22-stage bit-serial cube-root pipeline in each of the three lanes, and the
// merge stage. The whole pipeline advances when the output register is empty
// or being taken, so stall on the output holds every stage.
module xyz_to_cielab_core #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic [23:0]        x_value,
  input  wire logic [23:0]        y_value,
  input  wire logic [23:0]        z_value,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic [15:0]        lightness,
  output      logic signed [18:0] green_red,
  output      logic signed [17:0] blue_yellow
);
  localparam int Depth = 26;

  logic en;
  logic [Depth-1:0] vld;
  xyzlab_pkg::f_val_t fx, fy, fz;

  // Advance whenever the last stage is free or drains
  assign en       = !(vld[Depth-1] && out_stall);
  assign in_stall = !en;
  assign out_valid = vld[Depth-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Depth-2:0], in_valid};
    end
  end

  xyzlab_lane #(.FRAC_BITS(FRAC_BITS), .WHITE(xyzlab_pkg::WhiteX)) u_lx (
    .clk(clk), .en(en), .raw(x_value), .f_out(fx));
  xyzlab_lane #(.FRAC_BITS(FRAC_BITS), .WHITE(xyzlab_pkg::WhiteY)) u_ly (
    .clk(clk), .en(en), .raw(y_value), .f_out(fy));
  xyzlab_lane #(.FRAC_BITS(FRAC_BITS), .WHITE(xyzlab_pkg::WhiteZ)) u_lz (
    .clk(clk), .en(en), .raw(z_value), .f_out(fz));

  xyzlab_merge u_merge (
    .clk(clk), .en(en), .fx(fx), .fy(fy), .fz(fz),
    .lightness(lightness), .green_red(green_red), .blue_yellow(blue_yellow));

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(lightness))
    else $error("result dropped under stall");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without cause");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    !out_stall |=> vld[Depth-1] == $past(vld[Depth-2]))
    else $error("pipeline skipped a stage");
endmodule
`default_nettype wire

[rtl/xyzlab_lane.sv]
`default_nettype none
// One lane: normalize, then f(t), pipelined.
module xyzlab_lane #(
  parameter int FRAC_BITS = 16,
  parameter int unsigned WHITE = 1000000
) (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [23:0] raw,
  output      xyzlab_pkg::f_val_t f_out
);
  // Scale raw by 10000*2^(18-FRAC_BITS); shift down after the divide when
  // FRAC_BITS is above 18
  localparam int NumShift =
    (FRAC_BITS <= xyzlab_pkg::TFrac) ? xyzlab_pkg::TFrac - FRAC_BITS : 0;
  localparam int DenShift =
    (FRAC_BITS > xyzlab_pkg::TFrac) ? FRAC_BITS - xyzlab_pkg::TFrac : 0;
  localparam logic [47:0] Scale = 48'd10000 << NumShift;
  // Truncated Scale/WHITE with 24 fraction bits; the estimate it
  // gives is the true quotient or one below it
  localparam logic [63:0] Recip = (64'(Scale) << 24) / 64'(WHITE);

  // Pipeline entries carry t, the running root with its square and cube,
  // and the linear-segment value
  typedef struct packed {
    logic [xyzlab_pkg::TW-1:0] t;
    logic                      cube;
    logic [21:0]               y;
    logic [43:0]               y2;
    logic [65:0]               y3;
    logic [27:0]               ln;
    logic [xyzlab_pkg::FW-1:0] lin;
  } stage_t;

  logic [51:0] est_prod;
  logic [47:0] exact;
  logic [xyzlab_pkg::TW-1:0] qe;
  logic [47:0] ex;
  logic [48:0] back;
  logic [48:0] rem;
  logic [28:0] q0;
  logic [28:0] qs;
  logic [xyzlab_pkg::TW-1:0] t0;
  logic [xyzlab_pkg::TW-1:0] t1;
  logic [11:0] tl;
  logic [47:0] lin_num;
  logic [xyzlab_pkg::FW-1:0] lin_first;
  stage_t st [0:22];

  // Estimate t by reciprocal multiply, keep the exact scaled product
  assign est_prod = 52'(raw) * 52'(Recip[27:0]);
  assign exact    = 48'(raw) * Scale;
  always_ff @(posedge clk) begin
    if (en) begin
      qe <= est_prod[51:24];
      ex <= exact;
    end
  end

  // Correct the estimate by one compare and subtract, then saturate
  assign back = 49'(qe) * 49'(WHITE);
  assign rem  = 49'(ex) - back;
  assign q0   = 29'(qe) + ((rem >= 49'(WHITE)) ? 29'd1 : 29'd0);
  assign qs   = q0 >> DenShift;
  assign t0   = qs[28] ? {xyzlab_pkg::TW{1'b1}} : qs[xyzlab_pkg::TW-1:0];

  always_ff @(posedge clk) begin
    if (en) t1 <= t0;
  end

  // Segment choice and linear numerator; only small t take the linear
  // segment, so clamp t before the product
  assign tl      = (t1 > 28'd4095) ? 12'hFFF : t1[11:0];
  assign lin_num = 48'(tl) * 48'd24389 + xyzlab_pkg::LinOffset;
  always_ff @(posedge clk) begin
    if (en) begin
      st[0].t    <= t1;
      st[0].cube <= (48'(t1) * 48'd24389) > xyzlab_pkg::SegLimit;
      st[0].y    <= '0;
      st[0].y2   <= '0;
      st[0].y3   <= '0;
      st[0].ln   <= lin_num[27:0];
      st[0].lin  <= '0;
    end
  end

  // Divide the linear numerator by reciprocal multiply in the first root stage
  assign lin_first = xyzlab_pkg::FW'((64'(st[0].ln) * xyzlab_pkg::LinRecip)
                                     >> xyzlab_pkg::LinShift);

  // Cube root, one bit per stage, bit 21 down to 0; square and cube of the
  // candidate are built from the running values by shifts and adds
  for (genvar g = 0; g < 22; g++) begin : g_root
    localparam int Bit = 21 - g;
    logic [21:0] c;
    logic [43:0] c2;
    logic [65:0] c3;
    logic [65:0] r;
    stage_t nxt;
    assign c  = st[g].y | (22'd1 << Bit);
    assign c2 = st[g].y2 + (44'(st[g].y) << (Bit + 1)) + (44'd1 << (2 * Bit));
    assign c3 = st[g].y3 + 66'd3 * (66'(st[g].y2) << Bit)
              + 66'd3 * (66'(st[g].y) << (2 * Bit)) + (66'd1 << (3 * Bit));
    assign r  = 66'(st[g].t) << (2 * xyzlab_pkg::TFrac);
    always_comb begin
      nxt = st[g];
      if (c <= 22'd2642245 && c3 <= r) begin
        nxt.y  = c;
        nxt.y2 = c2;
        nxt.y3 = c3;
      end
      nxt.lin = (g == 0) ? lin_first : st[g].lin;
    end
    always_ff @(posedge clk) begin
      if (en) st[g+1] <= nxt;
    end
  end

  assign f_out = st[22].cube ? st[22].y[xyzlab_pkg::FW-1:0] : st[22].lin;
endmodule
`default_nettype wire

[rtl/xyzlab_merge.sv]
`default_nettype none
// Merge three lane results into L*, a*, b*, rounded and saturated.
module xyzlab_merge (
  input  wire logic clk,
  input  wire logic en,
  input  wire xyzlab_pkg::f_val_t fx,
  input  wire xyzlab_pkg::f_val_t fy,
  input  wire xyzlab_pkg::f_val_t fz,
  output      logic [15:0]        lightness,
  output      logic signed [18:0] green_red,
  output      logic signed [17:0] blue_yellow
);
  logic signed [31:0] lv, av, bv;
  logic signed [31:0] lq, aq, bq;

  // Form Q.18 sums, then round half up (arith shift = floor)
  always_comb begin
    lv = 32'sd116 * $signed({10'd0, fy}) - (32'sd16 <<< 18);
    av = 32'sd500 * ($signed({10'd0, fx}) - $signed({10'd0, fy}));
    bv = 32'sd200 * ($signed({10'd0, fy}) - $signed({10'd0, fz}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lq <= (lv + 32'sd512) >>> 10;
      aq <= (av + 32'sd512) >>> 10;
      bq <= (bv + 32'sd512) >>> 10;
    end
  end

  // Saturate
  always_comb begin
    lightness = (lq < 0) ? 16'd0 : (lq > 32'sd65535) ? 16'hFFFF : lq[15:0];
    green_red = (aq < -32'sd262144) ? -19'sd262144 :
                (aq > 32'sd262143) ? 19'sd262143 : aq[18:0];
    blue_yellow = (bq < -32'sd131072) ? -18'sd131072 :
                  (bq > 32'sd131071) ? 18'sd131071 : bq[17:0];
  end
endmodule
`default_nettype wire
